// ----- rtl/core/positional_list_insert_erase_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef POSITIONAL_LIST_INSERT_ERASE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_ERASE_MACROS_SVH

// Checked only while out of reset.
`define PLIE_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PLIE_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/plie_pkg.sv -----
// Shared types and constants of the positional list.
package plie_pkg;

	localparam int POS_W        = 8;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 9;
	localparam int CAPACITY_DEF = 256;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DRAIN,
		ST_PUT,
		ST_RDWAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       count_after;
	} res_t;

endpackage

// ----- rtl/core/plie_chan_if.sv -----
// Request and response channel interfaces.
interface plie_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         operation;
	logic [plie_pkg::POS_W-1:0]         position;
	logic signed [plie_pkg::DATA_W-1:0] value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

interface plie_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               ok;
	logic signed [plie_pkg::DATA_W-1:0] read_value;
	logic [plie_pkg::COUNT_W-1:0]       count_after;

	modport source (output valid, output ok, output read_value, output count_after,
		input ready);
	modport sink (input valid, input ok, input read_value, input count_after,
		output ready);
endinterface

// ----- rtl/core/plie_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/plie_ctrl.sv -----
// Request decode, range checks and the read-modify-write shift sequencer.
module plie_ctrl #(
	parameter int CAPACITY = plie_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	plie_req_if.sink                    req,
	output logic                        ram_wr_en,
	output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
	output logic [plie_pkg::DATA_W-1:0] ram_wr_data,
	output logic                        ram_rd_en,
	output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
	input  logic [plie_pkg::DATA_W-1:0] ram_rd_data,
	input  logic                        out_free,
	output logic                        res_load,
	output plie_pkg::res_t              res
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > plie_pkg::POS_W) ? CNT_W : plie_pkg::POS_W;
	localparam int EXT_W = (CNT_W > plie_pkg::COUNT_W) ? CNT_W : plie_pkg::COUNT_W;

	plie_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]            count_q;
	logic [AW-1:0]               rd_addr_q;
	logic [AW-1:0]               stop_q;
	logic [AW-1:0]               put_addr_q;
	logic [plie_pkg::DATA_W-1:0] put_val_q;
	logic                        ins_q;
	logic                        wr_pend_s1;
	logic [AW-1:0]               wr_addr_s1;
	plie_pkg::res_t              res_q;

	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic [AW-1:0]    pos_a;
	logic             full;
	logic             accept;
	logic             ins_ok, ers_ok, rd_ok;
	logic [CNT_W-1:0] count_new;
	logic [EXT_W-1:0] count_ext;
	logic             last_rd;

	assign pos_c     = CMP_W'(req.position);
	assign cnt_c     = CMP_W'(count_q);
	assign pos_a     = pos_c[AW-1:0];
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign accept    = req.valid && req.ready;
	assign ins_ok    = (req.operation == plie_pkg::OP_INSERT) && !full && (pos_c <= cnt_c);
	assign ers_ok    = (req.operation == plie_pkg::OP_ERASE) && (pos_c < cnt_c);
	assign rd_ok     = (req.operation == plie_pkg::OP_READ) && (pos_c < cnt_c);
	assign count_new = ins_ok ? count_q + CNT_W'(1) : (ers_ok ? count_q - CNT_W'(1) : count_q);
	assign count_ext = EXT_W'(count_new);
	assign last_rd   = (rd_addr_q == stop_q);

	assign req.ready = (state_q == plie_pkg::ST_IDLE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plie_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = wr_addr_s1;
		ram_wr_data = ram_rd_data;
		ram_rd_en   = 1'b0;
		ram_rd_addr = rd_addr_q;
		res_load    = 1'b0;
		case (state_q)
			plie_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = plie_pkg::ST_FINISH;
					if (ins_ok) begin
						if (pos_c == cnt_c) begin
							// append: nothing to move
							ram_wr_en   = 1'b1;
							ram_wr_addr = pos_a;
							ram_wr_data = req.value;
						end else begin
							state_d = plie_pkg::ST_SHIFT;
						end
					end else if (ers_ok) begin
						if (pos_c != cnt_c - CMP_W'(1)) begin
							state_d = plie_pkg::ST_SHIFT;
						end
					end else if (rd_ok) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = pos_a;
						state_d     = plie_pkg::ST_RDWAIT;
					end
				end
			end
			plie_pkg::ST_SHIFT: begin
				ram_rd_en = 1'b1;
				ram_wr_en = wr_pend_s1;
				if (last_rd) begin
					state_d = plie_pkg::ST_DRAIN;
				end
			end
			plie_pkg::ST_DRAIN: begin
				ram_wr_en = wr_pend_s1;
				state_d   = ins_q ? plie_pkg::ST_PUT : plie_pkg::ST_FINISH;
			end
			plie_pkg::ST_PUT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = put_addr_q;
				ram_wr_data = put_val_q;
				state_d     = plie_pkg::ST_FINISH;
			end
			plie_pkg::ST_RDWAIT: begin
				state_d = plie_pkg::ST_FINISH;
			end
			plie_pkg::ST_FINISH: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = plie_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plie_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_new;
			end
			wr_pend_s1 <= (state_q == plie_pkg::ST_SHIFT);
		end
	end

	// Insert walks down from the old tail, erase walks up to it; each read
	// is written back one place over in the following cycle.
	always_ff @(posedge clk) begin
		if (state_q == plie_pkg::ST_IDLE && accept) begin
			ins_q      <= ins_ok;
			put_addr_q <= pos_a;
			put_val_q  <= req.value;
			if (ins_ok) begin
				rd_addr_q <= AW'(count_q - CNT_W'(1));
				stop_q    <= pos_a;
			end else begin
				rd_addr_q <= pos_a + AW'(1);
				stop_q    <= AW'(count_q - CNT_W'(1));
			end
			res_q.ok          <= ins_ok || ers_ok || rd_ok;
			res_q.read_value  <= '0;
			res_q.count_after <= count_ext[plie_pkg::COUNT_W-1:0];
		end
		if (state_q == plie_pkg::ST_SHIFT) begin
			wr_addr_s1 <= ins_q ? rd_addr_q + AW'(1) : rd_addr_q - AW'(1);
			if (!last_rd) begin
				rd_addr_q <= ins_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
			end
		end
		if (state_q == plie_pkg::ST_RDWAIT) begin
			res_q.read_value <= ram_rd_data;
		end
	end

endmodule

// ----- rtl/core/plie_outreg.sv -----
// Response output register.
module plie_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  plie_pkg::res_t res,
	output logic           out_free,
	plie_rsp_if.source     rsp
);

	logic           valid_q;
	plie_pkg::res_t data_q;

	assign out_free        = !valid_q || rsp.ready;
	assign rsp.valid       = valid_q;
	assign rsp.ok          = data_q.ok;
	assign rsp.read_value  = data_q.read_value;
	assign rsp.count_after = data_q.count_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

endmodule

// ----- rtl/core/positional_list_insert_erase.sv -----
// Positional list of signed 32-bit entries held in one RAM of CAPACITY words. Requests are
// taken one at a time. A read passes through ST_RDWAIT before ST_FINISH loads the response
// register. A failed request, an append or an erase of the last entry goes straight to
// ST_FINISH. An erase that moves entries passes through ST_SHIFT and ST_DRAIN, and an insert
// that moves entries also passes through ST_PUT. Every moved entry costs one read and one
// write through the single RAM port pair, and an insert then writes the new value. The
// response sits in an output register and shows on rsp in the cycle after it is loaded. The
// next request is taken while it waits for a transfer; a response still held there stalls the
// block in ST_FINISH.
module positional_list_insert_erase #(
	parameter int CAPACITY = plie_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	plie_req_if.sink   req,
	plie_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                        ram_wr_en;
	logic [AW-1:0]               ram_wr_addr;
	logic [plie_pkg::DATA_W-1:0] ram_wr_data;
	logic                        ram_rd_en;
	logic [AW-1:0]               ram_rd_addr;
	logic [plie_pkg::DATA_W-1:0] ram_rd_data;
	logic                        out_free;
	logic                        res_load;
	plie_pkg::res_t              res;

	plie_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.ram_wr_en  (ram_wr_en),
		.ram_wr_addr(ram_wr_addr),
		.ram_wr_data(ram_wr_data),
		.ram_rd_en  (ram_rd_en),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res)
	);

	plie_ram #(
		.WIDTH(plie_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	plie_outreg u_outreg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_load),
		.res     (res),
		.out_free(out_free),
		.rsp     (rsp)
	);

endmodule

// ----- rtl/core/plie_chk.sv -----
// Port-level checker for the positional list, bound to the top level.
`include "positional_list_insert_erase_macros.svh"

module plie_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic                               rsp_ok,
	input logic signed [plie_pkg::DATA_W-1:0] rsp_read_value,
	input logic [plie_pkg::COUNT_W-1:0]       rsp_count_after
);

	logic [plie_pkg::COUNT_W-1:0] last_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			last_cnt_q <= rsp_count_after;
		end
	end

	`PLIE_ASSERT_ALWAYS(a_no_rsp_in_reset, clk, !arst_n |-> !rsp_valid, "response during reset")
	`PLIE_ASSERT_RST(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
	`PLIE_ASSERT_RST(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready |=> $stable(rsp_ok) && $stable(rsp_read_value) && $stable(rsp_count_after), "stalled response changed")
	`PLIE_ASSERT_RST(a_fail_zero, clk, arst_n, rsp_valid && !rsp_ok |-> rsp_read_value == '0, "failed request returned data")
	`PLIE_ASSERT_RST(a_count_step, clk, arst_n, rsp_valid && rsp_ready |-> (rsp_count_after == last_cnt_q) || (rsp_count_after == last_cnt_q + 9'd1) || (rsp_count_after == last_cnt_q - 9'd1), "count moved by more than one")

endmodule

bind positional_list_insert_erase plie_chk u_plie_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_read_value (rsp.read_value),
	.rsp_count_after(rsp.count_after)
);
